// ===== src/mtf_pkg.sv =====
// shared types, codes and constants for the modbus tcp master framer
// no dependencies; imported by every module of the block
package mtf_pkg;

    localparam int MAX_FRAME_BYTES = 260;
    localparam int RX_IDX_W        = $clog2(MAX_FRAME_BYTES + 1);

    // command codes on the input tuser
    localparam logic [1:0] CMD_REQ  = 2'd0;
    localparam logic [1:0] CMD_DATA = 2'd1;
    localparam logic [1:0] CMD_RX   = 2'd2;

    // result kinds on the output tuser
    localparam logic [1:0] KIND_TX     = 2'd0;
    localparam logic [1:0] KIND_REG    = 2'd1;
    localparam logic [1:0] KIND_COIL   = 2'd2;
    localparam logic [1:0] KIND_STATUS = 2'd3;

    // function codes
    localparam logic [7:0] FC_READ_COILS    = 8'd1;
    localparam logic [7:0] FC_READ_INPUTS   = 8'd2;
    localparam logic [7:0] FC_READ_HOLDING  = 8'd3;
    localparam logic [7:0] FC_READ_INPUT_RG = 8'd4;
    localparam logic [7:0] FC_WRITE_COIL    = 8'd5;
    localparam logic [7:0] FC_WRITE_REG     = 8'd6;
    localparam logic [7:0] FC_WRITE_COILS   = 8'd15;
    localparam logic [7:0] FC_WRITE_REGS    = 8'd16;
    localparam logic [7:0] FC_EXCEPTION     = 8'h80;

    // status codes
    localparam logic [2:0] ST_OK           = 3'd0;
    localparam logic [2:0] ST_ILLEGAL_FUNC = 3'd1;
    localparam logic [2:0] ST_GATEWAY      = 3'd7;

    localparam logic [15:0] COIL_ON = 16'hFF00;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [7:0]  func_code;
        logic [15:0] reg_address;
        logic [10:0] quantity;
        logic [15:0] data_word;
        logic [7:0]  rx_byte;
        logic        rx_last;
    } t_item;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  tx_byte;
        logic        frame_last;
        logic [15:0] reg_word;
        logic [7:0]  coil_bits;
        logic [3:0]  coil_count;
        logic [2:0]  status;
    } t_result;

    // exception code to status
    function automatic logic [2:0] classify(input logic [7:0] code);
        logic [2:0] st;
        if (code >= 8'd1 && code <= 8'd6) begin
            st = code[2:0];
        end else if (code == 8'd10 || code == 8'd11) begin
            st = ST_GATEWAY;
        end else begin
            st = ST_OK;
        end
        return st;
    endfunction

endpackage

// ===== src/mtf_core.sv =====
// protocol state and per-result logic of the modbus tcp master framer
// depends on mtf_pkg; state is updated once, when the held item is committed
module mtf_core
    import mtf_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_we,
    input  logic [7:0]    i_cfg_data,
    input  t_item         i_item,
    input  logic [3:0]    i_idx,
    input  logic          i_commit,
    output t_result       o_res,
    output logic [3:0]    o_count
);

    logic [15:0]         r_tid,    n_tid;
    logic [7:0]          r_efunc,  n_efunc;
    logic [10:0]         r_pq,     n_pq;
    logic [10:0]         r_ec,     n_ec;
    logic [7:0]          r_cacc,   n_cacc;
    logic [2:0]          r_cfill,  n_cfill;
    logic [RX_IDX_W-1:0] r_rxi,    n_rxi;
    logic [7:0]          r_rxhi,   n_rxhi;
    logic                r_exf,    n_exf;
    logic [7:0]          r_exc,    n_exc;
    logic [7:0]          r_unit;

    // request framing terms
    logic        known, multi;
    logic [15:0] tail;
    logic [11:0] bc;
    logic [11:0] qty_ext;
    logic [15:0] len;
    logic [3:0]  nbytes;
    logic [7:0]  fbyte;
    // data and response terms
    logic [11:0] ec_inc;
    logic        done;
    logic [7:0]  coil_byte;
    logic        coil_emit;
    logic        dec;
    t_result     dec_res;
    logic [10:0] rem;
    logic [3:0]  cnum;
    logic [8:0]  cmask;
    logic        in_range;

    always_comb begin
        qty_ext = {1'b0, i_item.quantity};
        known   = 1'b1;
        multi   = 1'b0;
        tail    = 16'd0;
        bc      = 12'd0;
        case (i_item.func_code)
            FC_READ_COILS, FC_READ_INPUTS, FC_READ_HOLDING, FC_READ_INPUT_RG: begin
                tail = {5'd0, i_item.quantity};
            end
            FC_WRITE_COIL: begin
                tail = i_item.data_word[0] ? COIL_ON : 16'd0;
            end
            FC_WRITE_REG: begin
                tail = i_item.data_word;
            end
            FC_WRITE_COILS: begin
                multi = 1'b1;
                tail  = {5'd0, i_item.quantity};
                bc    = (qty_ext + 12'd7) >> 3;
            end
            FC_WRITE_REGS: begin
                multi = 1'b1;
                tail  = {5'd0, i_item.quantity};
                bc    = {i_item.quantity, 1'b0};
            end
            default: begin
                known = 1'b0;
            end
        endcase
        len    = multi ? (16'd7 + {4'd0, bc}) : 16'd6;
        nbytes = multi ? 4'd13 : 4'd12;
        case (i_idx)
            4'd0:    fbyte = r_tid[15:8];
            4'd1:    fbyte = r_tid[7:0];
            4'd4:    fbyte = len[15:8];
            4'd5:    fbyte = len[7:0];
            4'd6:    fbyte = r_unit;
            4'd7:    fbyte = i_item.func_code;
            4'd8:    fbyte = i_item.reg_address[15:8];
            4'd9:    fbyte = i_item.reg_address[7:0];
            4'd10:   fbyte = tail[15:8];
            4'd11:   fbyte = tail[7:0];
            4'd12:   fbyte = bc[7:0];
            default: fbyte = 8'd0;
        endcase
    end

    always_comb begin
        ec_inc    = {1'b0, r_ec} + 12'd1;
        done      = (ec_inc == {1'b0, r_pq});
        coil_byte = r_cacc | ({7'd0, i_item.data_word[0]} << r_cfill);
        coil_emit = (r_cfill == 3'd7) || done;
        in_range  = ({{(32 - RX_IDX_W){1'b0}}, r_rxi} < 32'(MAX_FRAME_BYTES));
        rem       = r_pq - r_ec;
        cnum      = (rem > 11'd8) ? 4'd8 : rem[3:0];
        cmask     = (9'd1 << cnum) - 9'd1;
    end

    always_comb begin
        o_res   = '0;
        o_count = 4'd0;
        dec     = 1'b0;
        dec_res = '0;
        n_tid   = r_tid;
        n_efunc = r_efunc;
        n_pq    = r_pq;
        n_ec    = r_ec;
        n_cacc  = r_cacc;
        n_cfill = r_cfill;
        n_rxi   = r_rxi;
        n_rxhi  = r_rxhi;
        n_exf   = r_exf;
        n_exc   = r_exc;
        case (i_item.cmd)
            CMD_REQ: begin
                n_ec    = '0;
                n_cacc  = '0;
                n_cfill = '0;
                n_rxi   = '0;
                n_rxhi  = '0;
                n_exf   = 1'b0;
                n_exc   = '0;
                if (known) begin
                    o_count          = nbytes;
                    o_res.kind       = KIND_TX;
                    o_res.tx_byte    = fbyte;
                    o_res.frame_last = (i_idx == nbytes - 4'd1) &&
                                       (!multi || i_item.quantity == 11'd0);
                    n_efunc          = i_item.func_code;
                    n_pq             = i_item.quantity;
                    n_tid            = r_tid + 16'd1;
                end else begin
                    o_count      = 4'd1;
                    o_res.kind   = KIND_STATUS;
                    o_res.status = ST_ILLEGAL_FUNC;
                    n_efunc      = '0;
                    n_pq         = '0;
                end
            end
            CMD_DATA: begin
                if (r_ec < r_pq) begin
                    if (r_efunc == FC_WRITE_REGS) begin
                        o_count          = 4'd2;
                        o_res.kind       = KIND_TX;
                        o_res.tx_byte    = (i_idx == 4'd0) ? i_item.data_word[15:8]
                                                           : i_item.data_word[7:0];
                        o_res.frame_last = (i_idx != 4'd0) && done;
                        n_ec             = ec_inc[10:0];
                    end else if (r_efunc == FC_WRITE_COILS) begin
                        o_count          = coil_emit ? 4'd1 : 4'd0;
                        o_res.kind       = KIND_TX;
                        o_res.tx_byte    = coil_byte;
                        o_res.frame_last = done;
                        n_ec             = ec_inc[10:0];
                        n_cacc           = coil_emit ? 8'd0 : coil_byte;
                        n_cfill          = coil_emit ? 3'd0 : r_cfill + 3'd1;
                    end
                end
            end
            CMD_RX: begin
                if (in_range) begin
                    n_rxi = r_rxi + RX_IDX_W'(1);
                    if (r_rxi == RX_IDX_W'(7)) begin
                        if (r_efunc < FC_EXCEPTION &&
                            i_item.rx_byte == (r_efunc | FC_EXCEPTION)) begin
                            n_exf = 1'b1;
                        end
                    end else if (r_rxi == RX_IDX_W'(8)) begin
                        if (r_exf) begin
                            n_exc = i_item.rx_byte;
                        end
                    end else if (r_rxi >= RX_IDX_W'(9) && !r_exf && r_ec < r_pq) begin
                        if (r_efunc == FC_READ_HOLDING || r_efunc == FC_READ_INPUT_RG) begin
                            // payload starts at an odd index: odd is the high byte
                            if (r_rxi[0]) begin
                                n_rxhi = i_item.rx_byte;
                            end else begin
                                dec              = 1'b1;
                                dec_res.kind     = KIND_REG;
                                dec_res.reg_word = {r_rxhi, i_item.rx_byte};
                                n_ec             = ec_inc[10:0];
                            end
                        end else if (r_efunc == FC_READ_COILS ||
                                     r_efunc == FC_READ_INPUTS) begin
                            dec                = 1'b1;
                            dec_res.kind       = KIND_COIL;
                            dec_res.coil_bits  = i_item.rx_byte & cmask[7:0];
                            dec_res.coil_count = cnum;
                            n_ec               = r_ec + {7'd0, cnum};
                        end
                    end
                end
                o_count = {3'd0, dec} + {3'd0, i_item.rx_last};
                if (dec && i_idx == 4'd0) begin
                    o_res = dec_res;
                end else begin
                    o_res.kind   = KIND_STATUS;
                    o_res.status = n_exf ? classify(n_exc) : ST_OK;
                end
                if (i_item.rx_last) begin
                    n_rxi = '0;
                    n_exf = 1'b0;
                    n_exc = '0;
                end
            end
            default: begin
                o_count = 4'd0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tid   <= '0;
            r_efunc <= '0;
            r_pq    <= '0;
            r_ec    <= '0;
            r_cacc  <= '0;
            r_cfill <= '0;
            r_rxi   <= '0;
            r_rxhi  <= '0;
            r_exf   <= 1'b0;
            r_exc   <= '0;
            r_unit  <= '0;
        end else begin
            if (i_cfg_we) begin
                r_unit <= i_cfg_data;
            end
            if (i_commit) begin
                r_tid   <= n_tid;
                r_efunc <= n_efunc;
                r_pq    <= n_pq;
                r_ec    <= n_ec;
                r_cacc  <= n_cacc;
                r_cfill <= n_cfill;
                r_rxi   <= n_rxi;
                r_rxhi  <= n_rxhi;
                r_exf   <= n_exf;
                r_exc   <= n_exc;
            end
        end
    end

endmodule

// ===== src/mtf_out_reg.sv =====
// result register of the modbus tcp master framer, holds one item for the receiver
// depends on mtf_pkg for the result struct
module mtf_out_reg
    import mtf_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_load,
    input  t_result i_res,
    input  logic    i_ready,
    output logic    o_valid,
    output t_result o_res,
    output logic    o_free
);

    logic    r_valid;
    t_result r_res;

    assign o_free  = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_res   = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_free) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_free && i_load) begin
            r_res <= i_res;
        end
    end

endmodule

// ===== src/modbus_tcp_master_framer.sv =====
// modbus tcp master framer: item register, result sequencing and port packing
// depends on mtf_pkg, mtf_core and mtf_out_reg
//
// usage: items enter on the s_axis channel; tuser carries the command (start
// request, write data word, response byte) and tlast marks the last response
// byte. results leave on m_axis; tuser carries the kind (transmit byte,
// register word, coil bits, status) and tlast marks the final request byte.
// the user must write the unit id on the cfg channel only while the block is
// idle; the block does not enforce it. an accepted item sits in the item
// register and hands out one result per cycle into the output register while
// that register is free: a request gives 12 or 13 results (one for an unknown
// function), a multi-write register word 2, a coil bit 0 or 1 and a response
// byte 0 to 2. results reach m_axis from the output register; the next item
// is taken in the cycle the last result of the current one is loaded there.
// reset clears all protocol state and both valid flags; if the receiver holds
// tready low the output register holds its item and the sequence pauses.
module modbus_tcp_master_framer
    import mtf_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [7:0]  i_cfg_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,  // func_code, reg_address, quantity, data_word, rx_byte, zero fill
    input  logic [1:0]  s_axis_tuser,  // cmd
    input  logic        s_axis_tlast,  // rx_last
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,  // tx_byte, reg_word, coil_bits, coil_count, status, zero fill
    output logic [1:0]  m_axis_tuser,  // kind
    output logic        m_axis_tlast   // frame_last
);

    logic       r_busy;
    t_item      r_item;
    logic [3:0] r_idx;

    t_result    core_res;
    t_result    out_res;
    logic [3:0] count;
    logic       out_free;
    logic       emit;
    logic       finish;
    logic       accept;
    t_item      in_item;

    assign o_cfg_ready = 1'b1;

    assign in_item.cmd         = s_axis_tuser;
    assign in_item.func_code   = s_axis_tdata[7:0];
    assign in_item.reg_address = s_axis_tdata[23:8];
    assign in_item.quantity    = s_axis_tdata[34:24];
    assign in_item.data_word   = s_axis_tdata[50:35];
    assign in_item.rx_byte     = s_axis_tdata[58:51];
    assign in_item.rx_last     = s_axis_tlast;

    assign emit   = r_busy && (r_idx < count) && out_free;
    assign finish = r_busy && ((count == 4'd0) || (emit && r_idx == count - 4'd1));
    assign s_axis_tready = !r_busy || finish;
    assign accept = s_axis_tvalid && s_axis_tready;

    mtf_core u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_valid),
        .i_cfg_data (i_cfg_data),
        .i_item     (r_item),
        .i_idx      (r_idx),
        .i_commit   (finish),
        .o_res      (core_res),
        .o_count    (count)
    );

    mtf_out_reg u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (emit),
        .i_res   (core_res),
        .i_ready (m_axis_tready),
        .o_valid (m_axis_tvalid),
        .o_res   (out_res),
        .o_free  (out_free)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= '0;
        end else begin
            if (accept) begin
                r_busy <= 1'b1;
            end else if (finish) begin
                r_busy <= 1'b0;
            end
            if (finish) begin
                r_idx <= '0;
            end else if (emit) begin
                r_idx <= r_idx + 4'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item <= in_item;
        end
    end

    assign m_axis_tuser = out_res.kind;
    assign m_axis_tlast = out_res.frame_last;
    assign m_axis_tdata = {1'b0, out_res.status, out_res.coil_count, out_res.coil_bits,
                           out_res.reg_word, out_res.tx_byte};

endmodule

// ===== verif/tb_modbus_tcp_master_framer.sv =====
`timescale 1ns / 100ps
// testbench for modbus_tcp_master_framer: request, write data and response items go in,
// every transmit byte, register word, coil group and status is predicted and checked
// depends on mtf_pkg and the framer rtl
module tb_modbus_tcp_master_framer;
    import mtf_pkg::*;

    localparam logic [1:0] CMD_UNUSED = 2'd3;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [7:0]  i_cfg_data = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata = '0;  // func_code, reg_address, quantity, data_word, rx_byte, zero fill
    logic [1:0]  s_axis_tuser = '0;  // cmd
    logic        s_axis_tlast = 1'b0;  // rx_last
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [39:0] m_axis_tdata;  // tx_byte, reg_word, coil_bits, coil_count, status, zero fill
    logic [1:0]  m_axis_tuser;  // kind
    logic        m_axis_tlast;  // frame_last

    modbus_tcp_master_framer u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #5 i_clk = ~i_clk;

    // framer state as the testbench sees it
    logic [7:0]  unit_id_m;
    logic [15:0] txn_id;
    logic [7:0]  req_func;
    logic [10:0] req_qty;
    logic [10:0] elems_done;
    logic [7:0]  coil_acc;
    int          coil_fill_n;
    int          rx_pos;
    logic [7:0]  rx_hi;
    logic        exc_seen;
    logic [7:0]  exc_code;

    t_item   items_to_send[$];
    t_result framer_out_q[$];
    t_item   cur_item;
    int      items_made = 0;
    int      errors = 0;
    int      results_seen = 0;
    int      gap_left = 0;
    int      stall_left = 0;
    int      hold_left = 0;
    int      hold_done = 0;
    int      tx_calm = 0;
    int      rx_calm = 0;

    function automatic int idle_len(inout int calm);
        int r;
        if (calm > 0) begin
            calm--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 3) begin
            calm = $urandom_range(20, 60);
            return 0;
        end
        if (r < 55) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic string show(t_result r);
        return $sformatf("kind %0d tx %02h last %0b reg %04h coil %02h cnt %0d st %0d",
                         r.kind, r.tx_byte, r.frame_last, r.reg_word, r.coil_bits,
                         r.coil_count, r.status);
    endfunction

    function automatic void expect_tx(logic [7:0] b, logic last);
        t_result r;
        r = '0;
        r.kind = KIND_TX;
        r.tx_byte = b;
        r.frame_last = last;
        framer_out_q.push_back(r);
    endfunction

    // works out the results of one accepted item and advances the framer state
    function automatic void frame_and_decode(t_item it);
        logic [7:0] hdr [13];
        int         len, bc, n, tail, pos, rem, c, i;
        bit         multi;
        t_result    r;
        r = '0;
        case (it.cmd)
            CMD_REQ: begin
                elems_done = '0;
                coil_acc = '0;
                coil_fill_n = 0;
                rx_pos = 0;
                rx_hi = '0;
                exc_seen = 1'b0;
                exc_code = '0;
                bc = 0;
                n = 12;
                multi = 1'b0;
                len = 6;
                tail = it.quantity;
                case (it.func_code)
                    FC_READ_COILS, FC_READ_INPUTS, FC_READ_HOLDING, FC_READ_INPUT_RG: ;
                    FC_WRITE_COIL: tail = it.data_word[0] ? COIL_ON : 16'h0000;
                    FC_WRITE_REG:  tail = it.data_word;
                    FC_WRITE_COILS: begin
                        bc = (it.quantity + 7) / 8;
                        multi = 1'b1;
                    end
                    FC_WRITE_REGS: begin
                        bc = 2 * it.quantity;
                        multi = 1'b1;
                    end
                    default: begin
                        req_func = '0;
                        req_qty = '0;
                        r.kind = KIND_STATUS;
                        r.status = ST_ILLEGAL_FUNC;
                        framer_out_q.push_back(r);
                        return;
                    end
                endcase
                if (multi) begin
                    n = 13;
                    len = 7 + bc;
                end
                req_func = it.func_code;
                req_qty = it.quantity;
                hdr[0] = txn_id[15:8];
                hdr[1] = txn_id[7:0];
                hdr[2] = 8'h00;
                hdr[3] = 8'h00;
                hdr[4] = len[15:8];
                hdr[5] = len[7:0];
                hdr[6] = unit_id_m;
                hdr[7] = it.func_code;
                hdr[8] = it.reg_address[15:8];
                hdr[9] = it.reg_address[7:0];
                hdr[10] = tail[15:8];
                hdr[11] = tail[7:0];
                hdr[12] = bc[7:0];
                for (i = 0; i < n; i++) begin
                    expect_tx(hdr[i], (i == n - 1) && (!multi || it.quantity == 0));
                end
                txn_id = txn_id + 16'd1;
            end
            CMD_DATA: begin
                if (elems_done >= req_qty) return;
                if (req_func == FC_WRITE_REGS) begin
                    elems_done = elems_done + 11'd1;
                    expect_tx(it.data_word[15:8], 1'b0);
                    expect_tx(it.data_word[7:0], elems_done == req_qty);
                end else if (req_func == FC_WRITE_COILS) begin
                    coil_acc[coil_fill_n] = it.data_word[0];
                    coil_fill_n++;
                    elems_done = elems_done + 11'd1;
                    if (coil_fill_n >= 8 || elems_done == req_qty) begin
                        expect_tx(coil_acc, elems_done == req_qty);
                        coil_acc = '0;
                        coil_fill_n = 0;
                    end
                end
            end
            CMD_RX: begin
                if (rx_pos < MAX_FRAME_BYTES) begin
                    pos = rx_pos;
                    rx_pos++;
                    if (pos == 7) begin
                        if (req_func < FC_EXCEPTION && it.rx_byte == (req_func | FC_EXCEPTION))
                            exc_seen = 1'b1;
                    end else if (pos == 8) begin
                        if (exc_seen) exc_code = it.rx_byte;
                    end else if (pos >= 9 && !exc_seen && elems_done < req_qty) begin
                        if (req_func == FC_READ_HOLDING || req_func == FC_READ_INPUT_RG) begin
                            if ((pos - 9) % 2 == 0) begin
                                rx_hi = it.rx_byte;
                            end else begin
                                r.kind = KIND_REG;
                                r.reg_word = {rx_hi, it.rx_byte};
                                framer_out_q.push_back(r);
                                elems_done = elems_done + 11'd1;
                            end
                        end else if (req_func == FC_READ_COILS || req_func == FC_READ_INPUTS) begin
                            rem = req_qty - elems_done;
                            c = (rem > 8) ? 8 : rem;
                            r.kind = KIND_COIL;
                            r.coil_bits = it.rx_byte & 8'((1 << c) - 1);
                            r.coil_count = c[3:0];
                            framer_out_q.push_back(r);
                            elems_done = elems_done + c[10:0];
                        end
                    end
                end
                if (it.rx_last) begin
                    r = '0;
                    r.kind = KIND_STATUS;
                    r.status = ST_OK;
                    // exception codes 1..6 report as is, gateway codes fold into one
                    if (exc_seen) begin
                        case (exc_code)
                            8'd1, 8'd2, 8'd3, 8'd4, 8'd5, 8'd6: r.status = exc_code[2:0];
                            8'd10, 8'd11: r.status = ST_GATEWAY;
                            default: r.status = ST_OK;
                        endcase
                    end
                    framer_out_q.push_back(r);
                    rx_pos = 0;
                    exc_seen = 1'b0;
                    exc_code = '0;
                end
            end
            default: ;
        endcase
    endfunction

    // unused fields carry random values so every bit toggles
    function automatic t_item any_item();
        logic [63:0] raw;
        raw = {$urandom, $urandom};
        return raw[61:0];
    endfunction

    function automatic void push_req(logic [7:0] f, logic [15:0] addr, logic [10:0] qty,
                                     logic [15:0] dw);
        t_item it;
        it = any_item();
        it.cmd = CMD_REQ;
        it.func_code = f;
        it.reg_address = addr;
        it.quantity = qty;
        it.data_word = dw;
        items_to_send.push_back(it);
        items_made++;
    endfunction

    function automatic void push_data(logic [15:0] dw);
        t_item it;
        it = any_item();
        it.cmd = CMD_DATA;
        it.data_word = dw;
        items_to_send.push_back(it);
        items_made++;
    endfunction

    function automatic void push_rx(logic [7:0] b, logic last);
        t_item it;
        it = any_item();
        it.cmd = CMD_RX;
        it.rx_byte = b;
        it.rx_last = last;
        items_to_send.push_back(it);
        items_made++;
    endfunction

    // server reply: mostly well formed, some exceptions, bad function bytes,
    // short or overlong payloads
    function automatic void push_reply(logic [7:0] f, int qty);
        int         sel, nbytes, k;
        logic [7:0] code;
        sel = $urandom_range(0, 99);
        for (k = 0; k < 7; k++) push_rx(8'($urandom), 1'b0);
        if (sel < 15) begin
            if (sel < 3) begin
                push_rx(f | FC_EXCEPTION, 1'b1);
                return;
            end
            k = $urandom_range(0, 11);
            if (k < 6) code = 8'(k + 1);
            else if (k == 6) code = 8'd10;
            else if (k == 7) code = 8'd11;
            else code = 8'($urandom);
            push_rx(f | FC_EXCEPTION, 1'b0);
            push_rx(code, 1'b1);
            return;
        end
        push_rx((sel < 22) ? 8'($urandom) : f, 1'b0);
        if (f == FC_READ_HOLDING || f == FC_READ_INPUT_RG) nbytes = 2 * qty;
        else if (f == FC_READ_COILS || f == FC_READ_INPUTS) nbytes = (qty + 7) / 8;
        else nbytes = 3;
        if (nbytes > 40) nbytes = $urandom_range(20, 40);
        if (sel >= 90) nbytes += $urandom_range(1, 3);
        else if (sel >= 84 && nbytes > 0) nbytes -= $urandom_range(1, nbytes);
        push_rx(nbytes[7:0], nbytes == 0);
        for (k = 0; k < nbytes; k++) push_rx(8'($urandom), k == nbytes - 1);
    endfunction

    function automatic void gen_transaction();
        int         sel, qty, nd;
        logic [7:0] f;
        sel = $urandom_range(0, 99);
        if (sel < 8) begin
            repeat ($urandom_range(1, 4)) items_to_send.push_back(any_item());
            return;
        end
        case ($urandom_range(0, 9))
            0: f = FC_READ_COILS;
            1: f = FC_READ_INPUTS;
            2: f = FC_READ_HOLDING;
            3: f = FC_READ_INPUT_RG;
            4: f = FC_WRITE_COIL;
            5: f = FC_WRITE_REG;
            6: f = FC_WRITE_COILS;
            7: f = FC_WRITE_REGS;
            8: f = FC_WRITE_COILS;
            default: f = 8'($urandom);
        endcase
        qty = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 2047) : $urandom_range(0, 20);
        push_req(f, 16'($urandom), 11'(qty), 16'($urandom));
        if (f == FC_WRITE_COILS || f == FC_WRITE_REGS) begin
            nd = (qty > 24) ? $urandom_range(0, 24) : qty;
            if (sel < 18 && nd > 0) nd = $urandom_range(0, nd - 1);
            else if (sel > 92) nd += $urandom_range(1, 3);
            repeat (nd) push_data(16'($urandom));
        end
        if (f <= FC_READ_INPUT_RG || sel % 3 != 0) begin
            push_reply(f, qty);
            if (sel > 89) push_reply(f, qty);
        end
    endfunction

    // sender
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            gap_left = 0;
            unit_id_m = '0;
            txn_id = '0;
            req_func = '0;
            req_qty = '0;
            elems_done = '0;
            coil_acc = '0;
            coil_fill_n = 0;
            rx_pos = 0;
            rx_hi = '0;
            exc_seen = 1'b0;
            exc_code = '0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) frame_and_decode(cur_item);
            if (!s_axis_tvalid || s_axis_tready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_axis_tvalid <= 1'b0;
                end else if (items_to_send.size() != 0) begin
                    cur_item = items_to_send.pop_front();
                    s_axis_tdata <= {5'd0, cur_item.rx_byte, cur_item.data_word,
                                     cur_item.quantity, cur_item.reg_address,
                                     cur_item.func_code};
                    s_axis_tuser <= cur_item.cmd;
                    s_axis_tlast <= cur_item.rx_last;
                    s_axis_tvalid <= 1'b1;
                    gap_left = idle_len(tx_calm);
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // receiver and checker
    always @(posedge i_clk) begin
        t_result got, want;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            stall_left = 0;
            hold_left = 0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                got = '0;
                got.kind = m_axis_tuser;
                got.tx_byte = m_axis_tdata[7:0];
                got.frame_last = m_axis_tlast;
                got.reg_word = m_axis_tdata[23:8];
                got.coil_bits = m_axis_tdata[31:24];
                got.coil_count = m_axis_tdata[35:32];
                got.status = m_axis_tdata[38:36];
                if (framer_out_q.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected item, expected none, actual %s", $realtime,
                             show(got));
                end else begin
                    want = framer_out_q.pop_front();
                    if (got !== want) begin
                        errors++;
                        $display("%0t: mismatch, expected %s, actual %s", $realtime,
                                 show(want), show(got));
                    end
                end
                results_seen++;
            end
            // one long hold-off so the block backs up into its input
            if (results_seen >= 60 && hold_done == 0) begin
                hold_done = 1;
                hold_left = 400;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
                stall_left = idle_len(rx_calm);
            end
        end
    end

    task automatic write_unit_id(logic [7:0] v);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        unit_id_m = v;
    endtask

    // an item without results may still be in flight, so keep waiting after the queues drain
    task automatic wait_idle();
        do @(posedge i_clk);
        while (items_to_send.size() != 0 || s_axis_tvalid || framer_out_q.size() != 0);
        repeat (30) @(posedge i_clk);
    endtask

    task automatic random_phase(int n);
        int target;
        target = items_made + n;
        @(negedge i_clk);
        while (items_made < target) gen_transaction();
    endtask

    initial begin
        t_item odd;
        int    k;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        write_unit_id(8'hFF);
        @(negedge i_clk);
        push_req(8'h00, 16'h0000, 11'd0, 16'h0000);  // unknown function
        push_req(FC_WRITE_COIL, 16'hFFFF, 11'h7FF, 16'h0001);
        push_req(FC_WRITE_COIL, 16'h1234, 11'd0, 16'hFFFE);
        push_req(FC_WRITE_REG, 16'h0000, 11'd0, 16'hFFFF);
        push_req(FC_READ_COILS, 16'hFFFF, 11'd2047, 16'h0000);
        push_req(FC_READ_INPUT_RG, 16'h0000, 11'd0, 16'h0000);
        push_req(FC_WRITE_REGS, 16'h00FF, 11'd0, 16'h0000);  // frame ends at byte count
        push_req(FC_WRITE_REGS, 16'hFF00, 11'd128, 16'h0000);  // byte count wraps
        push_data(16'hFFFF);
        push_data(16'h0000);
        push_req(FC_WRITE_COILS, 16'h8001, 11'd3, 16'h0000);  // abandons the open write
        push_data(16'h0001);
        push_data(16'h0000);
        push_data(16'hFFFF);
        push_data(16'h0001);  // nothing left to write
        odd = any_item();
        odd.cmd = CMD_UNUSED;
        items_to_send.push_back(odd);
        push_req(FC_READ_HOLDING, 16'h0001, 11'd4, 16'h0000);
        for (k = 0; k < 7; k++) push_rx(8'($urandom), 1'b0);
        push_rx(FC_READ_HOLDING | FC_EXCEPTION, 1'b0);
        push_rx(8'd2, 1'b1);
        wait_idle();

        write_unit_id(8'h00);
        random_phase(35);
        wait_idle();

        write_unit_id(8'($urandom));
        random_phase(35);
        // reply longer than the frame buffer, then a short one
        push_req(FC_READ_HOLDING, 16'($urandom), 11'd2047, 16'($urandom));
        for (k = 0; k < 275; k++) push_rx(8'($urandom), k == 274);
        push_reply(FC_READ_HOLDING, 2047);
        wait_idle();

        write_unit_id(8'($urandom));
        random_phase(35);
        wait_idle();

        if (errors == 0 && framer_out_q.size() == 0) begin
            $display("tb: success");
        end else begin
            if (framer_out_q.size() != 0)
                $display("%0t: %0d expected items never arrived, next %s", $realtime,
                         framer_out_q.size(), show(framer_out_q[0]));
            $display("tb: failure");
        end
        $finish;
    end

    initial begin
        #40_000_000;
        $display("tb: failure");
        $finish;
    end

endmodule
